// File: rtl/core/swt_pkg.sv
package swt_pkg;

	localparam int SEQ_W = 32;
	localparam int OFF_W = 24;
	localparam int LEN_W = 16;

	// result status codes
	typedef enum logic [1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_ACKED     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	// input word kind
	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_ACK    = 1'b1
	} func_t;

	// controller state
	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_EXEC    = 5'b00010,
		ST_SEARCH  = 5'b00100,
		ST_ADVANCE = 5'b01000,
		ST_FINISH  = 5'b10000
	} state_t;

	// broadcast control from the controller to every slot cell
	typedef struct packed {
		logic load;  // place the scan token on the head cell
		logic move;  // token steps to the next cell
		logic wr;    // tail cell stores the new packet
		logic clr;   // token cell drops its outstanding bit
		logic adv;   // stop on outstanding or tail instead of seq match
	} cell_ctl_t;

endpackage

// File: rtl/core/sliding_window_tracker.sv
// Path from input accept to m_tvalid: an insert passes EXEC and FINISH; an ack passes EXEC,
// then SEARCH from the head over up to WINDOW_SLOTS slots, then, on a match at the head,
// ADVANCE until the token reaches an outstanding slot or the tail, then FINISH.
// A result word held by m_tready stalls FINISH. One word in flight; s_tready rises with m_tvalid.
// arst_n clears control, head, tail, count and all outstanding bits; slot data is unreset.
module sliding_window_tracker
	import swt_pkg::*;
#(
	parameter int WINDOW_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // seq_number[31:0], buffer_offset[55:32], packet_length[71:56]
	input  logic        s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // acked_offset, acked_length, head_slot, tail_slot, occupancy
	output logic [1:0]  m_tuser   // status
);

	localparam int IW = $clog2(WINDOW_SLOTS);
	localparam int CW = $clog2(WINDOW_SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_SLOTS - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW_SLOTS);

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
		next_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	state_t           state_q;
	func_t            func_q;
	logic [SEQ_W-1:0] key_q;
	logic [OFF_W-1:0] ioff_q;
	logic [LEN_W-1:0] ilen_q;
	logic [IW-1:0]    head_q;
	logic [IW-1:0]    tail_q;
	logic [CW-1:0]    live_q;
	logic [IW-1:0]    pos_q;
	logic [IW-1:0]    cnt_q;
	status_t          res_status_q;
	logic [OFF_W-1:0] res_off_q;
	logic [LEN_W-1:0] res_len_q;
	logic             m_tvalid_q;
	logic [55:0]      m_tdata_q;
	logic [1:0]       m_tuser_q;

	cell_ctl_t        ctl;
	logic             full;
	logic             stop_any;
	logic             out_free;
	logic [OFF_W-1:0] hit_off;
	logic [LEN_W-1:0] hit_len;

	logic [WINDOW_SLOTS-1:0] tok_v;
	logic [WINDOW_SLOTS-1:0] stop_v;
	logic [OFF_W-1:0]        off_v [WINDOW_SLOTS];
	logic [LEN_W-1:0]        len_v [WINDOW_SLOTS];

	assign full     = (live_q == FULL_CNT);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// ring of slot cells, token passes from cell i-1 to cell i
	for (genvar g = 0; g < WINDOW_SLOTS; g++) begin : g_cell
		swt_cell #(.IDX(g), .IW(IW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.head   (head_q),
			.tail   (tail_q),
			.key    (key_q),
			.wr_off (ioff_q),
			.wr_len (ilen_q),
			.tok_in (tok_v[(g + WINDOW_SLOTS - 1) % WINDOW_SLOTS]),
			.tok    (tok_v[g]),
			.stop   (stop_v[g]),
			.rd_off (off_v[g]),
			.rd_len (len_v[g])
		);
	end

	// only the token cell drives nonzero data
	always_comb begin
		hit_off = '0;
		hit_len = '0;
		for (int i = 0; i < WINDOW_SLOTS; i++) begin
			hit_off = hit_off | off_v[i];
			hit_len = hit_len | len_v[i];
		end
	end

	assign stop_any = |stop_v;

	// cell control
	always_comb begin
		ctl.load = (state_q == ST_EXEC) && (func_q == FUNC_ACK);
		ctl.wr   = (state_q == ST_EXEC) && (func_q == FUNC_INSERT) && !full;
		ctl.clr  = (state_q == ST_SEARCH) && stop_any;
		ctl.adv  = (state_q == ST_ADVANCE);
		ctl.move = ((state_q == ST_SEARCH) && !stop_any && (cnt_q != LAST_IDX)) ||
		           ((state_q == ST_SEARCH) && stop_any && (pos_q == head_q)) ||
		           ((state_q == ST_ADVANCE) && !stop_any);
	end

	// item registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= func_t'(s_tuser);
			key_q  <= s_tdata[31:0];
			ioff_q <= s_tdata[55:32];
			ilen_q <= s_tdata[71:56];
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			live_q  <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (func_q == FUNC_INSERT) begin
						if (!full) begin
							tail_q <= next_idx(tail_q);
							live_q <= live_q + 1'b1;
						end
						state_q <= ST_FINISH;
					end else begin
						pos_q   <= head_q;
						cnt_q   <= '0;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (stop_any) begin
						live_q <= live_q - 1'b1;
						if (pos_q == head_q) begin
							pos_q   <= next_idx(pos_q);
							state_q <= ST_ADVANCE;
						end else begin
							state_q <= ST_FINISH;
						end
					end else if (cnt_q == LAST_IDX) begin
						state_q <= ST_FINISH;
					end else begin
						pos_q <= next_idx(pos_q);
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_ADVANCE: begin
					if (stop_any) begin
						head_q  <= pos_q;
						state_q <= ST_FINISH;
					end else begin
						pos_q <= next_idx(pos_q);
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pending result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && func_q == FUNC_INSERT) begin
			res_status_q <= full ? STAT_FULL : STAT_INSERTED;
			res_off_q    <= '0;
			res_len_q    <= '0;
		end else if (state_q == ST_SEARCH) begin
			if (stop_any) begin
				res_status_q <= STAT_ACKED;
				res_off_q    <= hit_off;
				res_len_q    <= hit_len;
			end else begin
				res_status_q <= STAT_NOT_FOUND;
				res_off_q    <= '0;
				res_len_q    <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			m_tdata_q <= {6'(live_q), 5'(tail_q), 5'(head_q), res_len_q, res_off_q};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: rtl/core/swt_cell.sv
module swt_cell
	import swt_pkg::*;
#(
	parameter int IDX = 0,
	parameter int IW  = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [IW-1:0]    head,
	input  logic [IW-1:0]    tail,
	input  logic [SEQ_W-1:0] key,
	input  logic [OFF_W-1:0] wr_off,
	input  logic [LEN_W-1:0] wr_len,
	input  logic             tok_in,
	output logic             tok,
	output logic             stop,
	output logic [OFF_W-1:0] rd_off,
	output logic [LEN_W-1:0] rd_len
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic             tok_q;
	logic             out_q;
	logic [SEQ_W-1:0] seq_q;
	logic [OFF_W-1:0] off_q;
	logic [LEN_W-1:0] len_q;
	logic             is_head;
	logic             is_tail;

	assign is_head = (head == MY_IDX);
	assign is_tail = (tail == MY_IDX);

	// token and outstanding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
			out_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				tok_q <= is_head;
			end else if (ctl.move) begin
				tok_q <= tok_in;
			end
			if (ctl.wr && is_tail) begin
				out_q <= 1'b1;
			end else if (ctl.clr && tok_q) begin
				out_q <= 1'b0;
			end
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (ctl.wr && is_tail) begin
			seq_q <= key;
			off_q <= wr_off;
			len_q <= wr_len;
		end
	end

	assign tok    = tok_q;
	assign stop   = tok_q & (ctl.adv ? (out_q | is_tail) : (out_q & (seq_q == key)));
	assign rd_off = tok_q ? off_q : '0;
	assign rd_len = tok_q ? len_q : '0;

endmodule
